// File: hdl/rfpfd_pkg.sv
`timescale 1ns / 1ps

package rfpfd_pkg;

    localparam int DurationBits = 16;
    localparam int FrameBits    = 96;
    localparam int PreambleBits = 19;
    localparam int WordBits     = 48;

    localparam logic [DurationBits-1:0] ShortMinReset = 16'd96;
    localparam logic [DurationBits-1:0] ShortMaxReset = 16'd224;
    localparam logic [DurationBits-1:0] LongMinReset  = 16'd256;
    localparam logic [DurationBits-1:0] LongMaxReset  = 16'd384;

    localparam logic [1:0] CFG_SHORT_MIN = 2'd0;
    localparam logic [1:0] CFG_SHORT_MAX = 2'd1;
    localparam logic [1:0] CFG_LONG_MIN  = 2'd2;
    localparam logic [1:0] CFG_LONG_MAX  = 2'd3;

    localparam logic [PreambleBits-1:0] PRE_PLAIN = 19'h3FE00;
    localparam logic [PreambleBits-1:0] PRE_26    = 19'h3FE5A;
    localparam logic [PreambleBits-1:0] PRE_32    = 19'h3FE60;

    localparam logic [1:0] FMT_PLAIN = 2'd0;
    localparam logic [1:0] FMT_26    = 2'd1;
    localparam logic [1:0] FMT_32    = 2'd2;

    localparam logic [1:0] PH_START_1 = 2'd0;
    localparam logic [1:0] PH_MID_1   = 2'd1;
    localparam logic [1:0] PH_MID_0   = 2'd2;
    localparam logic [1:0] PH_START_0 = 2'd3;

    localparam logic [1:0] EV_SHORT_LOW  = 2'd0;
    localparam logic [1:0] EV_SHORT_HIGH = 2'd1;
    localparam logic [1:0] EV_LONG_LOW   = 2'd2;
    localparam logic [1:0] EV_LONG_HIGH  = 2'd3;

    typedef struct packed {
        logic [DurationBits-1:0] short_min;
        logic [DurationBits-1:0] short_max;
        logic [DurationBits-1:0] long_min;
        logic [DurationBits-1:0] long_max;
    } cfg_t;

    typedef struct packed {
        logic                    pulse_level;
        logic [DurationBits-1:0] pulse_duration;
    } pulse_t;

    typedef struct packed {
        logic        frame_found;
        logic [1:0]  card_format;
        logic [15:0] word_upper;
        logic [31:0] word_lower;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] code;
    } event_t;

    typedef struct packed {
        logic valid;
        logic value;
    } bit_t;

    function automatic logic [1:0] next_phase(input logic [1:0] ph, input logic [1:0] ev);
        logic [1:0] nx;
        nx = PH_MID_1;
        case (ph)
            PH_START_1: begin
                nx = (ev == EV_SHORT_LOW) ? PH_MID_1 : PH_START_1;
            end
            PH_MID_1: begin
                case (ev)
                    EV_SHORT_LOW:  nx = PH_MID_1;
                    EV_SHORT_HIGH: nx = PH_START_1;
                    EV_LONG_LOW:   nx = PH_MID_1;
                    default:       nx = PH_MID_0;
                endcase
            end
            PH_MID_0: begin
                case (ev)
                    EV_SHORT_LOW:  nx = PH_START_0;
                    EV_SHORT_HIGH: nx = PH_MID_0;
                    EV_LONG_LOW:   nx = PH_MID_1;
                    default:       nx = PH_MID_0;
                endcase
            end
            default: begin
                nx = (ev == EV_SHORT_HIGH) ? PH_MID_0 : PH_START_0;
            end
        endcase
        return nx;
    endfunction

endpackage

// File: hdl/rfpfd_classify.sv
`timescale 1ns / 1ps

module rfpfd_classify (
    input  rfpfd_pkg::cfg_t   cfg,
    input  rfpfd_pkg::pulse_t pulse,
    output rfpfd_pkg::event_t evt
);

    logic in_short;
    logic in_long;

    assign in_short = (pulse.pulse_duration > cfg.short_min) &&
                      (pulse.pulse_duration < cfg.short_max);
    assign in_long  = (pulse.pulse_duration > cfg.long_min) &&
                      (pulse.pulse_duration < cfg.long_max);

    // The short window wins when a duration falls in both.
    always_comb begin
        evt.valid = in_short || in_long;
        if (in_short) begin
            evt.code = pulse.pulse_level ? rfpfd_pkg::EV_SHORT_LOW : rfpfd_pkg::EV_SHORT_HIGH;
        end else begin
            evt.code = pulse.pulse_level ? rfpfd_pkg::EV_LONG_LOW : rfpfd_pkg::EV_LONG_HIGH;
        end
    end

endmodule

// File: hdl/rfpfd_manchester.sv
`timescale 1ns / 1ps

module rfpfd_manchester (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  rfpfd_pkg::event_t evt,
    output rfpfd_pkg::bit_t   bit_out
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [1:0] table_phase;

    assign table_phase = rfpfd_pkg::next_phase(phase_reg, evt.code);

    // A transition that leaves the phase where it was is illegal and resyncs to mid-1.
    always_comb begin
        phase_next    = phase_reg;
        bit_out.valid = 1'b0;
        bit_out.value = 1'b0;
        if (evt.valid) begin
            if (table_phase == phase_reg) begin
                phase_next = rfpfd_pkg::PH_MID_1;
            end else begin
                phase_next = table_phase;
                if (table_phase == rfpfd_pkg::PH_MID_0) begin
                    bit_out.valid = 1'b1;
                end else if (table_phase == rfpfd_pkg::PH_MID_1) begin
                    bit_out.valid = 1'b1;
                    bit_out.value = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rfpfd_pkg::PH_MID_1;
        end else if (advance) begin
            phase_reg <= phase_next;
        end
    end

endmodule

// File: hdl/rfpfd_frame.sv
`timescale 1ns / 1ps

module rfpfd_frame (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  rfpfd_pkg::bit_t    bit_in,
    output rfpfd_pkg::result_t result
);

    // Frame bit 0, the oldest bit, sits in the MSB of the window.
    logic [rfpfd_pkg::FrameBits-1:0]    window_reg;
    logic [rfpfd_pkg::FrameBits-1:0]    window_next;
    logic [rfpfd_pkg::PreambleBits-1:0] preamble;
    logic [rfpfd_pkg::WordBits-1:0]     word;
    logic                               found;
    logic [1:0]                         fmt;

    assign window_next = {window_reg[rfpfd_pkg::FrameBits-2:0], bit_in.value};
    assign preamble    = window_next[rfpfd_pkg::FrameBits-1 -: rfpfd_pkg::PreambleBits];

    always_comb begin
        found = 1'b0;
        fmt   = rfpfd_pkg::FMT_PLAIN;
        if (bit_in.valid) begin
            if (preamble == rfpfd_pkg::PRE_PLAIN) begin
                found = 1'b1;
                fmt   = rfpfd_pkg::FMT_PLAIN;
            end else if (preamble == rfpfd_pkg::PRE_26) begin
                found = 1'b1;
                fmt   = rfpfd_pkg::FMT_26;
            end else if (preamble == rfpfd_pkg::PRE_32) begin
                found = 1'b1;
                fmt   = rfpfd_pkg::FMT_32;
            end
        end
    end

    // Card word bit 0 is its MSB; spacer bits between the groups are skipped.
    always_comb begin
        word = '0;
        if (fmt == rfpfd_pkg::FMT_PLAIN) begin
            word[31:24] = window_next[66:59];
            word[23:16] = window_next[57:50];
            word[15:8]  = window_next[48:41];
            word[7:0]   = window_next[39:32];
        end else begin
            if (fmt == rfpfd_pkg::FMT_26) begin
                word[39] = window_next[59];
            end else begin
                word[45:39] = window_next[65:59];
            end
            word[38:32] = window_next[57:51];
            word[31]    = window_next[50];
            word[30:23] = window_next[48:41];
            word[22:16] = window_next[39:33];
            word[15:8]  = window_next[30:23];
            word[7:0]   = window_next[21:14];
        end
    end

    always_comb begin
        result.frame_found = found;
        result.card_format = found ? fmt : rfpfd_pkg::FMT_PLAIN;
        result.word_upper  = found ? word[47:32] : 16'd0;
        result.word_lower  = found ? word[31:0] : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (advance && bit_in.valid) begin
            window_reg <= window_next;
        end
    end

endmodule

// File: hdl/rfid_pulse_frame_decoder_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                     Beat
// pulse     in         s_valid s_ready s_data    one demodulated pulse
// result    out        m_valid m_ready m_data    one result per pulse beat
// config    in         cfg_we cfg_index cfg_wdata one window register write
//
// Each pulse beat gives exactly one result beat once it is taken.
// A new pulse beat is taken every cycle while results keep draining; the input
// register, one pass of compare, decode and field select, then the result register.
// Reset is synchronous and active low; it restores the window bounds, clears the
// frame window and puts the bit decoder in its mid-1 phase.
// A stalled result holds both stages; s_ready falls only when both are full.

module rfid_pulse_frame_decoder_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rfpfd_pkg::pulse_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rfpfd_pkg::result_t                  m_data,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [rfpfd_pkg::DurationBits-1:0]  cfg_wdata
);

    rfpfd_pkg::cfg_t    cfg_reg;
    rfpfd_pkg::pulse_t  pulse_reg;
    logic               pulse_valid_reg;
    rfpfd_pkg::result_t result_reg;
    logic               result_valid_reg;
    rfpfd_pkg::event_t  evt;
    rfpfd_pkg::bit_t    dec_bit;
    rfpfd_pkg::result_t result_next;
    logic               out_free;
    logic               advance;

    assign out_free = !result_valid_reg || m_ready;
    assign advance  = pulse_valid_reg && out_free;
    assign s_ready  = !pulse_valid_reg || out_free;
    assign m_valid  = result_valid_reg;
    assign m_data   = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_min <= rfpfd_pkg::ShortMinReset;
            cfg_reg.short_max <= rfpfd_pkg::ShortMaxReset;
            cfg_reg.long_min  <= rfpfd_pkg::LongMinReset;
            cfg_reg.long_max  <= rfpfd_pkg::LongMaxReset;
        end else if (cfg_we) begin
            case (cfg_index)
                rfpfd_pkg::CFG_SHORT_MIN: cfg_reg.short_min <= cfg_wdata;
                rfpfd_pkg::CFG_SHORT_MAX: cfg_reg.short_max <= cfg_wdata;
                rfpfd_pkg::CFG_LONG_MIN:  cfg_reg.long_min  <= cfg_wdata;
                rfpfd_pkg::CFG_LONG_MAX:  cfg_reg.long_max  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_valid_reg <= 1'b0;
        end else if (s_ready) begin
            pulse_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            pulse_reg <= s_data;
        end
    end

    rfpfd_classify u_classify (
        .cfg   (cfg_reg),
        .pulse (pulse_reg),
        .evt   (evt)
    );

    rfpfd_manchester u_manchester (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .evt     (evt),
        .bit_out (dec_bit)
    );

    rfpfd_frame u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .bit_in  (dec_bit),
        .result  (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_valid_reg <= 1'b0;
        end else if (out_free) begin
            result_valid_reg <= pulse_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

endmodule
